// ===== sv/ifcm_pkg.sv =====
package ifcm_pkg;

  localparam int unsigned OPS_W = 12;
  localparam int unsigned LUMA_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_OPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ODD_OPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_MODE = 2'd2;

  localparam logic [7:0] LUMA_R = 8'd76;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  typedef struct packed {
    logic [31:0] even_pixel;
    logic [31:0] odd_pixel;
    logic        line_start;
  } pixel_t;

  typedef struct packed {
    logic [31:0] even_result;
    logic [31:0] odd_result;
  } result_t;

  typedef struct packed {
    logic [OPS_W-1:0]  even_ops;
    logic [OPS_W-1:0]  odd_ops;
    logic [LUMA_W-1:0] luma_mode;
  } cfg_t;

  // bit2 red, bit1 green, bit0 blue
  function automatic logic [23:0] sel_mask(input logic [2:0] sel);
    sel_mask = {{8{sel[2]}}, {8{sel[1]}}, {8{sel[0]}}};
  endfunction

  // per-byte truncating average
  function automatic logic [23:0] avg_rgb(input logic [23:0] a, input logic [23:0] b);
    logic [8:0] s2, s1, s0;
    s2 = {1'b0, a[23:16]} + {1'b0, b[23:16]};
    s1 = {1'b0, a[15:8]} + {1'b0, b[15:8]};
    s0 = {1'b0, a[7:0]} + {1'b0, b[7:0]};
    avg_rgb = {s2[8:1], s1[8:1], s0[8:1]};
  endfunction

  // weights sum to 255, so the 16-bit sum cannot overflow
  function automatic logic [23:0] to_luma(input logic [23:0] p);
    logic [15:0] sum;
    sum = 16'(p[23:16]) * 16'(LUMA_R) + 16'(p[15:8]) * 16'(LUMA_G)
        + 16'(p[7:0]) * 16'(LUMA_B);
    to_luma = {3{sum[15:8]}};
  endfunction

endpackage

// ===== sv/ifcm_ops.sv =====
module ifcm_ops import ifcm_pkg::*; (
  input  pixel_t      pixel,
  input  cfg_t        cfg,
  input  logic [31:0] prev_even,
  input  logic [31:0] prev_odd,
  output result_t     result,
  output logic [31:0] prev_even_next,
  output logic [31:0] prev_odd_next
);

  always_comb begin
    logic [31:0] ev, od, cur, pe, po;
    logic [23:0] n;
    ev = pixel.even_pixel;
    od = pixel.odd_pixel;
    cur = '0;
    pe = pixel.line_start ? pixel.even_pixel : prev_even;
    po = pixel.line_start ? pixel.odd_pixel : prev_odd;
    prev_even_next = pe;
    prev_odd_next = po;

    // clone even to odd
    n = sel_mask(cfg.even_ops[2:0]);
    if (|n) od = {8'h00, (od[23:0] & ~n) | (ev[23:0] & n)};
    // cancel even
    n = sel_mask(cfg.even_ops[5:3]);
    if (|n) ev = {8'h00, ev[23:0] & ~n};
    // blend into even
    n = sel_mask(cfg.even_ops[8:6]);
    if (|n) ev = {8'h00, avg_rgb(ev[23:0] & n, od[23:0] & n) | (ev[23:0] & ~n)};
    // blur even, history takes the pre-blur pixel
    n = sel_mask(cfg.even_ops[11:9]);
    if (|n) begin
      cur = ev;
      ev = {8'h00, avg_rgb(cur[23:0] & n, pe[23:0] & n) | (cur[23:0] & ~n)};
      prev_even_next = cur;
    end

    // clone odd to even
    n = sel_mask(cfg.odd_ops[2:0]);
    if (|n) ev = {8'h00, (ev[23:0] & ~n) | (od[23:0] & n)};
    // cancel odd
    n = sel_mask(cfg.odd_ops[5:3]);
    if (|n) od = {8'h00, od[23:0] & ~n};
    // blend into odd
    n = sel_mask(cfg.odd_ops[8:6]);
    if (|n) od = {8'h00, avg_rgb(ev[23:0] & n, od[23:0] & n) | (od[23:0] & ~n)};
    // blur odd
    n = sel_mask(cfg.odd_ops[11:9]);
    if (|n) begin
      cur = od;
      od = {8'h00, avg_rgb(po[23:0] & n, cur[23:0] & n) | (cur[23:0] & ~n)};
      prev_odd_next = cur;
    end

    if (cfg.luma_mode[0]) ev = {8'h00, to_luma(ev[23:0])};
    if (cfg.luma_mode[1]) od = {8'h00, to_luma(od[23:0])};

    result.even_result = ev;
    result.odd_result = od;
  end

endmodule

// ===== sv/interlaced_field_channel_mixer.sv =====
// channel   | signals                                  | moves
// ----------+------------------------------------------+-------------------------------
// pixel in  | pixel_valid, pixel_stall, pixel          | even/odd pixel pair, line_start
// result    | result_valid, result_stall, result       | processed even/odd pixel pair
// config    | cfg_write, cfg_index, cfg_data           | even_ops, odd_ops, luma_mode
//
// One transaction per clock while result_stall is low; a pair passes the input
// register, then the result register behind the single-pass operation logic.
// rst (synchronous) clears config, blur history and both valid flags.
// A stalled result holds; the input register still fills behind it, and
// pixel_stall rises only when both registers are occupied.
module interlaced_field_channel_mixer import ifcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  pixel_t               pixel,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OPS_W-1:0]     cfg_data
);

  cfg_t        cfg;
  pixel_t      stage;
  logic        stage_valid;
  logic [31:0] prev_even, prev_odd;
  logic [31:0] prev_even_next, prev_odd_next;
  result_t     result_next;
  logic        out_free, stage_move;

  assign out_free    = !result_valid || !result_stall;
  assign stage_move  = stage_valid && out_free;
  assign pixel_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EVEN_OPS:  cfg.even_ops <= cfg_data;
        REG_ODD_OPS:   cfg.odd_ops <= cfg_data;
        REG_LUMA_MODE: cfg.luma_mode <= cfg_data[LUMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!pixel_stall) begin
      stage_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_stall && pixel_valid) stage <= pixel;
  end

  ifcm_ops u_ops (
    .pixel          (stage),
    .cfg            (cfg),
    .prev_even      (prev_even),
    .prev_odd       (prev_odd),
    .result         (result_next),
    .prev_even_next (prev_even_next),
    .prev_odd_next  (prev_odd_next)
  );

  // blur history advances with each transaction leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_even <= '0;
      prev_odd <= '0;
    end else if (stage_move) begin
      prev_even <= prev_even_next;
      prev_odd <= prev_odd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) result <= result_next;
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> !pixel_stall)
    else $error("input stalled with empty input register");

  a_move_gives_result: assert property (@(posedge clk) disable iff (rst)
    stage_move |=> result_valid)
    else $error("moved transaction did not reach the result register");

  a_history_even_hold: assert property (@(posedge clk) disable iff (rst)
    (!stage_move) |=> $stable(prev_even) && $stable(prev_odd))
    else $error("blur history changed without a transaction");

  a_luma_even_alpha: assert property (@(posedge clk) disable iff (rst)
    (stage_move && cfg.luma_mode[0]) |=> (result.even_result[31:24] == 8'h00))
    else $error("even luma result kept its alpha byte");

  a_luma_odd_alpha: assert property (@(posedge clk) disable iff (rst)
    (stage_move && cfg.luma_mode[1]) |=> (result.odd_result[31:24] == 8'h00))
    else $error("odd luma result kept its alpha byte");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ifcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 2000;

  // one directed row: register settings, input pair, and optionally a typed-in result
  typedef struct packed {
    cfg_t    cfg;
    pixel_t  px;
    bit      known;
    result_t res;
  } vector_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  pixel_t               pixel = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OPS_W-1:0]     cfg_data = '0;

  // typed-in expectation travels with the pixel pair, driven on the same edge
  bit      row_known = 1'b0;
  result_t row_result = '0;

  cfg_t        live_cfg = '0;
  logic [31:0] hist_even = '0;
  logic [31:0] hist_odd = '0;
  result_t     pending_q[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          gap_pct = 19;
  int          stall_pct = 47;

  interlaced_field_channel_mixer u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [23:0] lanes(input logic [2:0] sel);
    logic [23:0] m;
    m = '0;
    for (int i = 0; i < 3; i++) if (sel[i]) m[8*i +: 8] = 8'hff;
    return m;
  endfunction

  function automatic logic [23:0] lane_avg(input logic [23:0] a, input logic [23:0] b);
    logic [23:0] r;
    for (int i = 0; i < 3; i++) r[8*i +: 8] = 8'((9'(a[8*i +: 8]) + 9'(b[8*i +: 8])) >> 1);
    return r;
  endfunction

  function automatic logic [31:0] gray(input logic [31:0] p);
    logic [31:0] acc;
    acc = 32'(p[23:16]) * 32'(LUMA_R) + 32'(p[15:8]) * 32'(LUMA_G)
        + 32'(p[7:0]) * 32'(LUMA_B);
    return {8'h00, {3{acc[15:8]}}};
  endfunction

  // processes one column pair; updates a line's blur history on line start or when its blur is on
  function automatic result_t mix_pixel_pair(input pixel_t p);
    logic [31:0] ev, od, pre;
    logic [23:0] m;
    ev = p.even_pixel;
    od = p.odd_pixel;
    if (p.line_start) begin
      hist_even = ev;
      hist_odd = od;
    end
    m = lanes(live_cfg.even_ops[2:0]);
    if (m != 0) od = {8'h00, (od[23:0] & ~m) | (ev[23:0] & m)};
    m = lanes(live_cfg.even_ops[5:3]);
    if (m != 0) ev = {8'h00, ev[23:0] & ~m};
    m = lanes(live_cfg.even_ops[8:6]);
    if (m != 0) ev = {8'h00, (lane_avg(ev[23:0], od[23:0]) & m) | (ev[23:0] & ~m)};
    m = lanes(live_cfg.even_ops[11:9]);
    if (m != 0) begin
      pre = ev;
      ev = {8'h00, (lane_avg(pre[23:0], hist_even[23:0]) & m) | (pre[23:0] & ~m)};
      hist_even = pre;
    end
    m = lanes(live_cfg.odd_ops[2:0]);
    if (m != 0) ev = {8'h00, (ev[23:0] & ~m) | (od[23:0] & m)};
    m = lanes(live_cfg.odd_ops[5:3]);
    if (m != 0) od = {8'h00, od[23:0] & ~m};
    m = lanes(live_cfg.odd_ops[8:6]);
    if (m != 0) od = {8'h00, (lane_avg(ev[23:0], od[23:0]) & m) | (od[23:0] & ~m)};
    m = lanes(live_cfg.odd_ops[11:9]);
    if (m != 0) begin
      pre = od;
      od = {8'h00, (lane_avg(hist_odd[23:0], pre[23:0]) & m) | (pre[23:0] & ~m)};
      hist_odd = pre;
    end
    if (live_cfg.luma_mode[0]) ev = gray(ev);
    if (live_cfg.luma_mode[1]) od = gray(od);
    return {ev, od};
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t predicted;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction %h", $time, result);
        end else begin
          want = pending_q.pop_front();
          if (result.even_result !== want.even_result) begin
            fail_count++;
            $display("%0t: even_result expected %h actual %h", $time,
                     want.even_result, result.even_result);
          end
          if (result.odd_result !== want.odd_result) begin
            fail_count++;
            $display("%0t: odd_result expected %h actual %h", $time,
                     want.odd_result, result.odd_result);
          end
        end
      end
      if (pixel_valid && !pixel_stall) begin
        predicted = mix_pixel_pair(pixel);
        pending_q.push_back(row_known ? row_result : predicted);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_pair(input pixel_t p, input bit known, input result_t res);
    if ($urandom_range(99) < gap_pct) begin
      pixel_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    row_known <= known;
    row_result <= res;
    do @(posedge clk); while (pixel_stall);
  endtask

  // holds off the sender until every pending result is out, plus pipeline slack
  task automatic wait_for_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // caller lowers cfg_write once the batch is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OPS_W-1:0] word);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    case (idx)
      REG_EVEN_OPS:  live_cfg.even_ops = word;
      REG_ODD_OPS:   live_cfg.odd_ops = word;
      REG_LUMA_MODE: live_cfg.luma_mode = word[LUMA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [OPS_W-1:0] even_word, odd_word, luma_word,
                             input bit poke_unused);
    wait_for_results();
    write_reg(REG_EVEN_OPS, even_word);
    write_reg(REG_ODD_OPS, odd_word);
    write_reg(REG_LUMA_MODE, luma_word);
    if (poke_unused) write_reg(REG_UNUSED, OPS_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  // each operation group enabled half the time, with a random channel mix
  function automatic logic [OPS_W-1:0] random_ops();
    logic [OPS_W-1:0] w;
    w = '0;
    for (int g = 0; g < 4; g++) if ($urandom_range(1)) w[3*g +: 3] = 3'($urandom_range(7, 1));
    return w;
  endfunction

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    vector_t directed_vecs[$];
    vector_t v;
    pixel_t  px;
    int      col;
    int      line_len;

    // even_ops, odd_ops, luma | even, odd, line_start | known, even_result, odd_result
    // reset settings pass both pixels through untouched
    directed_vecs.push_back({12'h000, 12'h000, 2'd0, 32'h00000000, 32'h00000000, 1'b0,
                             1'b1, 32'h00000000, 32'h00000000});
    directed_vecs.push_back({12'h000, 12'h000, 2'd0, 32'hffffffff, 32'hffffffff, 1'b0,
                             1'b1, 32'hffffffff, 32'hffffffff});
    directed_vecs.push_back({12'h000, 12'h000, 2'd0, 32'h12345678, 32'h9abcdef0, 1'b0,
                             1'b1, 32'h12345678, 32'h9abcdef0});
    // blur with no line start yet: history is still zero
    directed_vecs.push_back({12'he00, 12'he00, 2'd0, 32'hffffffff, 32'hffffffff, 1'b0,
                             1'b1, 32'h007f7f7f, 32'h007f7f7f});
    directed_vecs.push_back({12'he00, 12'he00, 2'd0, 32'h80402010, 32'h01020304, 1'b1,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'he00, 12'he00, 2'd0, 32'hffffffff, 32'h00000000, 1'b0,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'h038, 12'h000, 2'd0, 32'hffffffff, 32'ha5a5a5a5, 1'b1,
                             1'b1, 32'h00000000, 32'ha5a5a5a5});
    directed_vecs.push_back({12'h000, 12'h038, 2'd0, 32'hc3c3c3c3, 32'hffffffff, 1'b0,
                             1'b1, 32'hc3c3c3c3, 32'h00000000});
    directed_vecs.push_back({12'h007, 12'h000, 2'd0, 32'h11223344, 32'h55667788, 1'b0,
                             1'b1, 32'h11223344, 32'h00223344});
    directed_vecs.push_back({12'h000, 12'h007, 2'd0, 32'h11223344, 32'h55667788, 1'b0,
                             1'b1, 32'h00667788, 32'h55667788});
    directed_vecs.push_back({12'h1c0, 12'h000, 2'd0, 32'hfefefefe, 32'h01010101, 1'b0,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'h000, 12'h1c0, 2'd0, 32'hff00ff00, 32'h00ff00ff, 1'b0,
                             1'b0, 64'h0});
    // luma clears alpha, even on black
    directed_vecs.push_back({12'h000, 12'h000, 2'd3, 32'hffffffff, 32'h00000000, 1'b0,
                             1'b1, 32'h00fefefe, 32'h00000000});
    directed_vecs.push_back({12'h000, 12'h000, 2'd1, 32'h00ff0000, 32'h0000ff00, 1'b0,
                             1'b1, 32'h004b4b4b, 32'h0000ff00});
    directed_vecs.push_back({12'h000, 12'h000, 2'd2, 32'h00ff0000, 32'h0000ff00, 1'b0,
                             1'b1, 32'h00ff0000, 32'h00959595});
    // single-channel masks: red on even, green on odd, then blue on both
    directed_vecs.push_back({12'h924, 12'h492, 2'd0, 32'h8899aabb, 32'h33445566, 1'b1,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'h249, 12'h249, 2'd0, 32'hf0e1d2c3, 32'h0f1e2d3c, 1'b0,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'hfff, 12'hfff, 2'd3, 32'hffffffff, 32'hffffffff, 1'b1,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'hfff, 12'hfff, 2'd3, 32'h00000000, 32'hffffffff, 1'b0,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'hfff, 12'hfff, 2'd0, 32'h5a5a5a5a, 32'ha5a5a5a5, 1'b0,
                             1'b0, 64'h0});
    // even blur off for one column: its history must hold
    directed_vecs.push_back({12'h000, 12'he00, 2'd0, 32'h77777777, 32'h88888888, 1'b0,
                             1'b0, 64'h0});
    directed_vecs.push_back({12'he00, 12'he00, 2'd0, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b0,
                             1'b0, 64'h0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_vecs[i]) begin
      v = directed_vecs[i];
      if (v.cfg != live_cfg)
        load_config(v.cfg.even_ops, v.cfg.odd_ops, OPS_W'(v.cfg.luma_mode), 1'b0);
      send_pair(v.px, v.known, v.res);
    end

    col = 0;
    line_len = 8;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
      stall_pct = (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        // luma data wider than the register on every write; upper bits must drop
        if (phase == 0 && seg == 0)
          load_config(12'hfff, 12'hfff, 12'hfff, 1'b1);
        else if (phase == 1 && seg == 0)
          load_config(12'h000, 12'h000, 12'hffc, 1'b1);
        else
          load_config(random_ops(), random_ops(), OPS_W'($urandom), 1'b1);
        for (int n = 0; n < 50; n++) begin
          if (col == 0) line_len = $urandom_range(40, 2);
          px.even_pixel = random_pixel();
          px.odd_pixel = random_pixel();
          // mostly well-formed lines, with a stray line start now and then
          px.line_start = (col == 0) || ($urandom_range(31) == 0);
          col = (col + 1) % line_len;
          send_pair(px, 1'b0, 64'h0);
        end
      end
    end

    wait_for_results();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
